[rtl/hkma_pkg.sv]
// Package with shared constants, types and the slot hash constants for the key metric accumulator.
package hkma_pkg;

	localparam int TableSlots = 1024;
	localparam int SlotW      = $clog2(TableSlots);
	localparam int KeyW       = 64;
	localparam int ValW       = 64;
	// One entry: valid, key, invocations, sum a, sum b, sum c.
	localparam int EntryW     = 5 * ValW + 1;
	localparam int MemDepth   = 2 * TableSlots;
	localparam int MemAw      = SlotW + 1;

	localparam logic [63:0] HashBasis = 64'hCBF29CE484222325;
	localparam logic [63:0] HashPrime = 64'h00000100000001B3;

	localparam logic [1:0] StUpdated  = 2'd0;
	localparam logic [1:0] StInserted = 2'd1;
	localparam logic [1:0] StZeroKey  = 2'd2;
	localparam logic [1:0] StFull     = 2'd3;

	typedef struct packed {
		logic            valid;
		logic [ValW-1:0] sum_c;
		logic [ValW-1:0] sum_b;
		logic [ValW-1:0] sum_a;
		logic [ValW-1:0] invocations;
		logic [KeyW-1:0] key;
	} entry_t;

endpackage

[rtl/hkma_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hkma_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/hkma_hash.sv]
// Registered FNV-1a slot hash built from a shift and a small constant product.
module hkma_hash import hkma_pkg::*; (
	input  logic             clk,
	input  logic [KeyW-1:0]  key,
	output logic [SlotW-1:0] slot
);
	// The prime is 2^40 + 0x1B3; only the low bits of the product matter.
	logic [63:0] x_s1;
	logic [63:0] prod;

	always_ff @(posedge clk) begin
		x_s1 <= HashBasis ^ key;
	end

	assign prod = (x_s1 << 40) + (x_s1 * 64'h1B3);

	always_ff @(posedge clk) begin
		slot <= prod[SlotW-1:0];
	end
endmodule

[rtl/hashed_key_metric_accumulator_top.sv]
// Top level of the hashed key metric accumulator: probe sequencer and entry memory.
//
// Channel  Direction  Contents (tdata low bit first)
// s_axis   in         tuser: action; tdata: key, value_a, value_b, value_c
// m_axis   out        tdata: status, slot, invocations, total_a, total_b, total_c,
//                     collision_count
//
// A zero key goes from idle to the output state. A keyed item passes the hash,
// read and check states, then a wait and a check state per extra probe, as reads
// are registered. After reset a clearing pass writes all 2048 entries, one per
// cycle, with the input held off. The input is taken whenever the sequencer is
// idle; a finished result waits in its last state until the output register is
// free, so a stalled output holds one result and blocks.
module hashed_key_metric_accumulator_top import hkma_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // key, value_a, value_b, value_c
	input  logic         s_axis_tuser,  // action
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [335:0] m_axis_tdata   // status, slot, invocations, total_a..c, collision_count
);
	localparam logic [2:0] SIdle  = 3'd0;
	localparam logic [2:0] SHash  = 3'd1;
	localparam logic [2:0] SRead  = 3'd2;
	localparam logic [2:0] SCheck = 3'd3;
	localparam logic [2:0] SOut   = 3'd4;
	localparam logic [2:0] SWait  = 3'd5;
	localparam logic [2:0] SClear = 3'd6;

	logic [2:0]       state_q;
	logic             act_q;
	logic [KeyW-1:0]  key_q;
	logic [ValW-1:0]  va_q, vb_q, vc_q;
	logic [SlotW-1:0] start_q, idx_q;
	logic [SlotW:0]   steps_q;
	logic [MemAw-1:0] clr_q;
	logic [ValW-1:0]  tcoll_q, dcoll_q;
	logic [SlotW-1:0] hslot;
	logic             out_v_q;
	logic [335:0]     out_q;

	logic             we;
	entry_t           wentry, rentry, mentry;
	logic [MemAw-1:0] raddr, waddr;
	logic             vbit;
	logic [SlotW-1:0] nidx;
	logic [ValW-1:0]  coll, inv_n, a_n, b_n, c_n;
	logic             hit;
	logic             full_n;
	logic             clearing;
	logic             out_free;
	logic             out_load;

	hkma_hash u_hash (.clk(clk), .key(s_axis_tdata[63:0]), .slot(hslot));

	hkma_ram #(.Width(EntryW), .Depth(MemDepth)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(mentry),
		.raddr(raddr), .rdata(rentry)
	);

	assign s_axis_tready = (state_q == SIdle);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// Probe bookkeeping and update arithmetic.
	assign clearing = (state_q == SClear);
	assign raddr = {act_q, (state_q == SRead) ? hslot : idx_q};
	assign waddr = clearing ? clr_q : {act_q, idx_q};
	assign vbit  = rentry.valid;
	assign hit   = vbit && (rentry.key == key_q);
	assign nidx  = idx_q + 1'b1;
	assign full_n = (nidx == start_q) || (steps_q + 1'b1 >= (SlotW+1)'(TableSlots));
	assign coll  = act_q ? dcoll_q : tcoll_q;
	assign inv_n = (vbit ? rentry.invocations : '0) + 64'd1;
	assign a_n   = (vbit ? rentry.sum_a : '0) + va_q;
	assign b_n   = (vbit ? rentry.sum_b : '0) + vb_q;
	assign c_n   = act_q ? ((vbit ? rentry.sum_c : '0) + vc_q) : '0;
	assign out_free = !out_v_q || m_axis_tready;
	assign out_load = out_free && (((state_q == SCheck) && (hit || !vbit || full_n)) ||
		(state_q == SOut));
	assign we    = clearing || ((state_q == SCheck) && out_free && (hit || !vbit));
	assign wentry = '{valid: 1'b1, sum_c: c_n, sum_b: b_n, sum_a: a_n, invocations: inv_n,
		key: key_q};
	assign mentry = clearing ? '0 : wentry;

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// Probe sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SClear;
			clr_q   <= '0;
			act_q   <= 1'b0;
			key_q   <= '0;
			va_q    <= '0;
			vb_q    <= '0;
			vc_q    <= '0;
			start_q <= '0;
			idx_q   <= '0;
			steps_q <= '0;
			out_q   <= '0;
			tcoll_q <= '0;
			dcoll_q <= '0;
		end else begin
			unique case (state_q)
				SClear: begin
					// Write one empty entry per cycle over both tables.
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= SIdle;
				end
				SIdle: begin
					if (s_axis_tvalid && s_axis_tready) begin
						act_q   <= s_axis_tuser;
						key_q   <= s_axis_tdata[63:0];
						va_q    <= s_axis_tdata[127:64];
						vb_q    <= s_axis_tdata[191:128];
						vc_q    <= s_axis_tdata[255:192];
						steps_q <= '0;
						state_q <= (s_axis_tdata[63:0] == '0) ? SOut : SHash;
					end
				end
				SHash: begin
					// The first hash register holds the key XOR the basis; slot is ready next.
					state_q <= SRead;
				end
				SRead: begin
					start_q <= hslot;
					idx_q   <= hslot;
					state_q <= SCheck;
				end
				SCheck: begin
					if (out_free) begin
						if (hit || !vbit) begin
							out_q   <= {4'd0, coll, c_n, b_n, a_n, inv_n, 10'(idx_q),
								vbit ? StUpdated : StInserted};
							state_q <= SIdle;
						end else if (full_n) begin
							out_q   <= {4'd0, coll, 256'd0, 10'd0, StFull};
							state_q <= SIdle;
						end else begin
							if (act_q) dcoll_q <= dcoll_q + 64'd1;
							else       tcoll_q <= tcoll_q + 64'd1;
							steps_q <= steps_q + 1'b1;
							idx_q   <= nidx;
							state_q <= SWait;
						end
					end
				end
				SOut: begin
					if (out_free) begin
						out_q   <= {4'd0, coll, 256'd0, 10'd0, StZeroKey};
						state_q <= SIdle;
					end
				end
				SWait: begin
					// Wait for the next slot's registered read.
					state_q <= SCheck;
				end
				default: state_q <= SIdle;
			endcase
		end
	end

	// A result is only loaded by the sequencer and is held while stalled; memory is written only in check or clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q) != SIdle) else $error("result without work");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_axis_tready |=> out_v_q && $stable(m_axis_tdata))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == SCheck || state_q == SClear)) else $error("write outside check");
endmodule

[tb/hashed_key_metric_accumulator_top_tb.sv]
// Testbench for the hashed key metric accumulator: random stream stimulus, table predictor, field checks.
`timescale 1ns / 1ps

module hashed_key_metric_accumulator_top_tb;
	import hkma_pkg::*;

	localparam int Slots      = TableSlots;
	localparam int CycleLimit = 10000000;
	localparam int CalmTail   = 200;
	localparam bit TaskTable  = 1'b0;
	localparam bit DataTable  = 1'b1;

	typedef struct {
		bit          action;
		logic [63:0] key;
		logic [63:0] va;
		logic [63:0] vb;
		logic [63:0] vc;
	} record_t;

	typedef struct {
		logic [1:0]  status;
		logic [9:0]  slot;
		logic [63:0] invocations;
		logic [63:0] total_a;
		logic [63:0] total_b;
		logic [63:0] total_c;
		logic [63:0] collisions;
	} totals_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;  // key, value_a, value_b, value_c
	logic         s_axis_tuser;  // action
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [335:0] m_axis_tdata;  // status, slot, invocations, total_a..c, collision_count

	hashed_key_metric_accumulator_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of both tables.
	bit          shadow_valid [2][Slots];
	logic [63:0] shadow_key   [2][Slots];
	logic [63:0] shadow_inv   [2][Slots];
	logic [63:0] shadow_sum_a [2][Slots];
	logic [63:0] shadow_sum_b [2][Slots];
	logic [63:0] shadow_sum_c [2][Slots];
	logic [63:0] shadow_coll  [2];

	record_t     records_to_send [$];
	totals_t     expected_totals [$];
	logic [63:0] task_keys [$];
	logic [63:0] data_keys [$];

	int errors;
	int records_sent;
	int totals_seen;
	int full_seen;
	int inserted_seen;
	int cycle_count;
	int send_gap;
	int recv_gap;
	int recv_hold;
	bit hold_done;
	bit calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [9:0] home_slot(input logic [63:0] key);
		logic [63:0] h;
		h = (HashBasis ^ key) * HashPrime;
		return h[9:0];
	endfunction

	function automatic logic [63:0] rand_value();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return 64'd0;
		if (pick == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	// Work out the totals one record produces and update the shadow tables.
	function automatic void accumulate(input record_t r);
		totals_t     t;
		int          tb_i;
		logic [9:0]  start;
		logic [9:0]  idx;
		bit          searching;
		bit          full;
		tb_i = r.action;
		t = '{default: '0};
		if (r.key == 64'd0) begin
			t.status = StZeroKey;
			t.collisions = shadow_coll[tb_i];
			expected_totals.push_back(t);
			return;
		end
		start = home_slot(r.key);
		idx = start;
		full = 1'b0;
		searching = shadow_valid[tb_i][idx] && shadow_key[tb_i][idx] != r.key;
		while (searching) begin
			idx = idx + 10'd1;
			if (idx == start) begin
				full = 1'b1;
				searching = 1'b0;
			end else begin
				shadow_coll[tb_i] = shadow_coll[tb_i] + 64'd1;
				searching = shadow_valid[tb_i][idx] && shadow_key[tb_i][idx] != r.key;
			end
		end
		if (full) begin
			t.status = StFull;
		end else begin
			if (shadow_valid[tb_i][idx]) begin
				t.status = StUpdated;
			end else begin
				t.status = StInserted;
				shadow_valid[tb_i][idx] = 1'b1;
				shadow_key[tb_i][idx] = r.key;
				shadow_inv[tb_i][idx] = '0;
				shadow_sum_a[tb_i][idx] = '0;
				shadow_sum_b[tb_i][idx] = '0;
				shadow_sum_c[tb_i][idx] = '0;
			end
			shadow_inv[tb_i][idx] = shadow_inv[tb_i][idx] + 64'd1;
			shadow_sum_a[tb_i][idx] = shadow_sum_a[tb_i][idx] + r.va;
			shadow_sum_b[tb_i][idx] = shadow_sum_b[tb_i][idx] + r.vb;
			// The task table has no third sum.
			if (r.action == DataTable)
				shadow_sum_c[tb_i][idx] = shadow_sum_c[tb_i][idx] + r.vc;
			t.slot = idx;
			t.invocations = shadow_inv[tb_i][idx];
			t.total_a = shadow_sum_a[tb_i][idx];
			t.total_b = shadow_sum_b[tb_i][idx];
			t.total_c = shadow_sum_c[tb_i][idx];
		end
		t.collisions = shadow_coll[tb_i];
		expected_totals.push_back(t);
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("MISMATCH result %0d %s: got %h expected %h", totals_seen, field, got, want);
	endtask

	task automatic queue_record(input bit action, input logic [63:0] key,
			input logic [63:0] va, input logic [63:0] vb, input logic [63:0] vc);
		record_t r;
		r = '{action, key, va, vb, vc};
		records_to_send.push_back(r);
		if (key != 64'd0) begin
			if (action == DataTable) data_keys.push_back(key);
			else task_keys.push_back(key);
		end
	endtask

	// Stimulus: directed cases, mixed random traffic, a fill of the data table, then a tail.
	initial begin
		logic [63:0] k;
		logic [63:0] twin;
		bit          act;
		int          n;
		errors = 0;
		for (int i = 0; i < Slots; i++) begin
			shadow_valid[0][i] = 1'b0;
			shadow_valid[1][i] = 1'b0;
		end
		shadow_coll[0] = '0;
		shadow_coll[1] = '0;

		// Zero keys on both tables, extreme keys and values wrapping the sums.
		queue_record(TaskTable, 64'd0, '1, '1, '1);
		queue_record(DataTable, 64'd0, '1, '1, '1);
		queue_record(TaskTable, '1, '1, '1, '1);
		queue_record(TaskTable, '1, '1, '1, '1);
		queue_record(DataTable, '1, '1, '1, '1);
		queue_record(DataTable, '1, '1, '1, '1);
		queue_record(DataTable, 64'd1, 64'd0, 64'd0, 64'd0);
		queue_record(TaskTable, 64'd1, 64'd0, 64'd0, '1);
		// Keys that share a home slot force probing past an occupied slot.
		twin = 64'd2;
		n = 0;
		while (n < 3) begin
			if (home_slot(twin) == home_slot(64'd1)) begin
				queue_record(TaskTable, twin, 64'd5, 64'd7, 64'd9);
				queue_record(DataTable, twin, 64'd5, 64'd7, 64'd9);
				n++;
			end
			twin++;
		end
		queue_record(TaskTable, 64'd1, 64'd3, 64'd4, 64'd5);
		queue_record(DataTable, twin - 64'd1, 64'd1, 64'd1, 64'd1);

		// Mixed traffic over small key pools so entries keep updating.
		for (int i = 0; i < 560; i++) begin
			act = $urandom_range(0, 1);
			if ($urandom_range(0, 19) == 0) k = 64'd0;
			else if ($urandom_range(0, 3) == 0 || (act ? data_keys.size() : task_keys.size()) == 0)
				k = {$urandom, $urandom};
			else if (act) k = data_keys[$urandom_range(0, data_keys.size() - 1)];
			else k = task_keys[$urandom_range(0, task_keys.size() - 1)];
			queue_record(act, k, rand_value(), rand_value(), rand_value());
		end

		// Fresh keys overfill the data table so the full case shows up.
		for (int i = 0; i < 1100; i++) begin
			k = {$urandom, $urandom} | 64'd1;
			queue_record(DataTable, k, rand_value(), rand_value(), rand_value());
			if (i % 50 == 0)
				queue_record(TaskTable, task_keys[$urandom_range(0, task_keys.size() - 1)],
					rand_value(), rand_value(), rand_value());
		end

		// Tail: updates on a full data table plus task traffic.
		for (int i = 0; i < 250; i++) begin
			act = $urandom_range(0, 1);
			if ($urandom_range(0, 15) == 0) k = 64'd0;
			else if (act) k = data_keys[$urandom_range(0, data_keys.size() - 1)];
			else k = task_keys[$urandom_range(0, task_keys.size() - 1)];
			queue_record(act, k, rand_value(), rand_value(), rand_value());
		end

		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		wait (records_to_send.size() == 0 && expected_totals.size() == 0);
		repeat (50) @(posedge clk);
		$display("Sent %0d records over both tables; %0d results checked.",
			records_sent, totals_seen);
		$display("Inserts seen: %0d, full-table results: %0d, long output stall applied.",
			inserted_seen, full_seen);
		if (errors == 0 && expected_totals.size() == 0) begin
			$display("hashed_key_metric_accumulator_top_tb passed");
		end else begin
			$display("hashed_key_metric_accumulator_top_tb failed");
		end
		$finish;
	end

	assign calm = records_to_send.size() < CalmTail;

	// Driver: offers the head record; on each accepted beat predicts and moves on.
	always @(posedge clk or negedge arst_n) begin
		bit      next_valid;
		record_t head;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			send_gap <= 0;
			records_sent <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				accumulate(records_to_send.pop_front());
				records_sent <= records_sent + 1;
			end
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 7);
			end else if (records_to_send.size() > 0) begin
				next_valid = 1'b1;
			end
			// A beat on offer but not yet taken must stay put.
			if (s_axis_tvalid && !s_axis_tready) next_valid = 1'b1;
			s_axis_tvalid <= next_valid;
			if (next_valid && records_to_send.size() > 0) begin
				head = records_to_send[0];
				s_axis_tdata <= {head.vc, head.vb, head.va, head.key};
				s_axis_tuser <= head.action;
			end
		end
	end

	// Monitor: random output stalls, one long hold, and field checks on each beat.
	always @(posedge clk or negedge arst_n) begin
		totals_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
			recv_hold <= 0;
			hold_done <= 1'b0;
			totals_seen <= 0;
			full_seen <= 0;
			inserted_seen <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_totals.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[63:0], 64'd0);
				end else begin
					want = expected_totals.pop_front();
					if (m_axis_tdata[1:0] != want.status)
						report_mismatch("status", m_axis_tdata[1:0], want.status);
					if (m_axis_tdata[11:2] != want.slot)
						report_mismatch("slot", m_axis_tdata[11:2], want.slot);
					if (m_axis_tdata[75:12] != want.invocations)
						report_mismatch("invocations", m_axis_tdata[75:12], want.invocations);
					if (m_axis_tdata[139:76] != want.total_a)
						report_mismatch("total_a", m_axis_tdata[139:76], want.total_a);
					if (m_axis_tdata[203:140] != want.total_b)
						report_mismatch("total_b", m_axis_tdata[203:140], want.total_b);
					if (m_axis_tdata[267:204] != want.total_c)
						report_mismatch("total_c", m_axis_tdata[267:204], want.total_c);
					if (m_axis_tdata[331:268] != want.collisions)
						report_mismatch("collision_count", m_axis_tdata[331:268],
							want.collisions);
					if (want.status == StFull) full_seen <= full_seen + 1;
					if (want.status == StInserted) inserted_seen <= inserted_seen + 1;
				end
				totals_seen <= totals_seen + 1;
			end
			if (!hold_done && totals_seen == 150) begin
				recv_hold <= 400;
				hold_done <= 1'b1;
				m_axis_tready <= 1'b0;
			end else if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				recv_gap <= $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > CycleLimit) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("hashed_key_metric_accumulator_top_tb failed");
				$finish;
			end
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
	end

endmodule
